// ===== src/fpm_pkg.sv =====
// fpm_pkg: sizes, entry layouts, memory request structs and controller states
// for the flash page map with block compaction.
// No dependencies; every other file of the block imports it.
package fpm_pkg;

  // Geometry
  localparam int SUPERBLOCKS           = 4;
  localparam int PAGES_PER_BLOCK       = 16;
  localparam int BLOCKS_PER_SUPERBLOCK = 8;
  localparam int PAGES_PER_SUPERBLOCK  = PAGES_PER_BLOCK * BLOCKS_PER_SUPERBLOCK;
  localparam int PHYS_PAGES            = SUPERBLOCKS * PAGES_PER_SUPERBLOCK;
  localparam int LOGICAL_PAGES         = 512;

  // Widths
  localparam int LP_W    = 9;                              // logical page
  localparam int SB_W    = (SUPERBLOCKS > 1) ? $clog2(SUPERBLOCKS) : 1;
  localparam int PPB_W   = $clog2(PAGES_PER_BLOCK);        // page within block
  localparam int POS_W   = $clog2(PAGES_PER_SUPERBLOCK);   // pointer position
  localparam int PHYS_W  = $clog2(PHYS_PAGES);             // physical page
  localparam int CNT_W   = $clog2(PAGES_PER_BLOCK + 1);    // 0..PAGES_PER_BLOCK
  localparam int OUT_PG_W = 9;
  localparam int COPY_W  = 5;
  localparam int TOT_W   = 32;
  localparam int CLR_PAGES = (PHYS_PAGES > LOGICAL_PAGES) ? PHYS_PAGES : LOGICAL_PAGES;
  localparam int CLR_W   = $clog2(CLR_PAGES);

  // Status codes
  localparam logic STATUS_WRITTEN = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  // Forward map entry: logical -> physical
  typedef struct packed {
    logic              mapped;
    logic [PHYS_W-1:0] page;
  } fwd_entry_t;

  // Page table entry: invalid flag plus reverse map
  typedef struct packed {
    logic            invalid;
    logic [LP_W-1:0] lpage;
  } pt_entry_t;

  typedef struct packed {
    logic            we;
    logic [LP_W-1:0] waddr;
    fwd_entry_t      wdata;
    logic            re;
    logic [LP_W-1:0] raddr;
  } fwd_req_t;

  typedef struct packed {
    logic              we;
    logic [PHYS_W-1:0] waddr;
    pt_entry_t         wdata;
    logic              re;
    logic [PHYS_W-1:0] raddr;
  } pt_req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_REFUSE,
    ST_FWD_RD,
    ST_INVAL,
    ST_PLACE
  } fpm_state_t;

  // Physical page from superblock and pointer position
  function automatic logic [PHYS_W-1:0] phys_addr(input logic [SB_W-1:0] sb,
                                                  input logic [POS_W-1:0] pos);
    logic [PHYS_W-1:0] sb_base;
    sb_base = PHYS_W'(PHYS_W'(sb) << POS_W);
    return sb_base | PHYS_W'(pos);
  endfunction

endpackage

// ===== src/fpm_if.sv =====
// fpm_in_if / fpm_out_if: valid/ready channels carrying a logical page write
// and its result transaction. Depends on fpm_pkg for field widths.
interface fpm_in_if;
  import fpm_pkg::*;
  logic            valid;
  logic            ready;
  logic [LP_W-1:0] logical_page;

  modport source (output valid, output logical_page, input ready);
  modport sink   (input valid, input logical_page, output ready);
endinterface

interface fpm_out_if;
  import fpm_pkg::*;
  logic                valid;
  logic                ready;
  logic [OUT_PG_W-1:0] physical_page;
  logic                compaction_ran;
  logic [COPY_W-1:0]   pages_copied;
  logic                status;
  logic [TOT_W-1:0]    compaction_total;
  logic [TOT_W-1:0]    copies_total;

  modport source (output valid, output physical_page, output compaction_ran,
                  output pages_copied, output status, output compaction_total,
                  output copies_total, input ready);
  modport sink   (input valid, input physical_page, input compaction_ran,
                  input pages_copied, input status, input compaction_total,
                  input copies_total, output ready);
endinterface

// ===== src/fpm_fwd_map.sv =====
// fpm_fwd_map: forward map memory, one entry per logical page.
// One write and one registered read per cycle. Depends on fpm_pkg.
module fpm_fwd_map (
  input  logic              clk,
  input  fpm_pkg::fwd_req_t req,
  output fpm_pkg::fwd_entry_t rdata
);
  import fpm_pkg::*;

  fwd_entry_t mem [LOGICAL_PAGES];

  // Write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// ===== src/fpm_page_table.sv =====
// fpm_page_table: per physical page invalid flag and reverse map in one memory.
// One write and one registered read per cycle. Depends on fpm_pkg.
module fpm_page_table (
  input  logic             clk,
  input  fpm_pkg::pt_req_t req,
  output fpm_pkg::pt_entry_t rdata
);
  import fpm_pkg::*;

  pt_entry_t mem [PHYS_PAGES];

  // Write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// ===== src/fpm_ctrl.sv =====
// fpm_ctrl: sequencer for clearing, block compaction and page placement,
// write pointers, running counters and the result register.
// Depends on fpm_pkg and the channel interfaces in fpm_if.sv.
module fpm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  fpm_in_if.sink               in_chan,
  fpm_out_if.source            out_chan,
  output fpm_pkg::fwd_req_t    fwd_req,
  input  fpm_pkg::fwd_entry_t  fwd_rdata,
  output fpm_pkg::pt_req_t     pt_req,
  input  fpm_pkg::pt_entry_t   pt_rdata
);
  import fpm_pkg::*;

  fpm_state_t state_r, state_nxt;

  logic [CLR_W-1:0]  clr_r;
  logic [LP_W-1:0]   lp_r;
  logic [SB_W-1:0]   sb_r;
  logic [POS_W-1:0]  pos_r;
  logic [CNT_W-1:0]  rd_cnt_r;
  logic              pend_r;
  logic [CNT_W-1:0]  dst_r;
  logic [PPB_W-1:0]  tail_r;
  logic              ran_r;
  logic [POS_W-1:0]  wptr_r [SUPERBLOCKS];
  logic [SUPERBLOCKS-1:0] wrap_r;
  logic [TOT_W-1:0]  comp_cnt_r;
  logic [TOT_W-1:0]  copy_cnt_r;

  logic                out_valid_r;
  logic [OUT_PG_W-1:0] out_page_r;
  logic                out_ran_r;
  logic [COPY_W-1:0]   out_copied_r;
  logic                out_status_r;
  logic [TOT_W-1:0]    out_ctot_r;
  logic [TOT_W-1:0]    out_cptot_r;

  logic [POS_W-1:0]  ptr_nxt;
  logic              wrap_set;
  logic              in_fire;
  logic [SB_W-1:0]   in_sb;
  logic [POS_W-1:0]  in_pos;
  logic              scan_issue;
  logic              scan_done;
  logic              out_free;
  logic              out_ld;
  logic              refusing;
  logic [PHYS_W-1:0] phys_cur;

  // Page inside the block under compaction
  function automatic logic [PHYS_W-1:0] blk_page(input logic [SB_W-1:0] sb,
                                                 input logic [POS_W-1:0] pos,
                                                 input logic [PPB_W-1:0] off);
    return phys_addr(sb, {pos[POS_W-1:PPB_W], off});
  endfunction

  assign in_sb    = SB_W'(in_chan.logical_page % SUPERBLOCKS);
  assign in_pos   = wptr_r[in_sb];
  assign in_fire  = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == ST_IDLE);

  assign scan_issue = (rd_cnt_r < CNT_W'(PAGES_PER_BLOCK));
  assign scan_done  = !scan_issue && !pend_r;
  assign out_free   = !out_valid_r || out_chan.ready;
  assign refusing   = (state_r == ST_REFUSE);
  assign out_ld     = out_free && ((state_r == ST_PLACE) || refusing);
  assign phys_cur   = phys_addr(sb_r, pos_r);

  // Pointer advance: one page after a write, a whole block after a refusal
  always_comb begin
    logic [POS_W:0] sum;
    sum      = '0;
    wrap_set = 1'b0;
    if (refusing) begin
      sum = {1'b0, pos_r} + (POS_W+1)'(PAGES_PER_BLOCK);
    end else begin
      sum = {1'b0, pos_r} + (POS_W+1)'(1);
    end
    if (sum >= (POS_W+1)'(PAGES_PER_SUPERBLOCK)) begin
      ptr_nxt  = '0;
      wrap_set = !refusing;
    end else begin
      ptr_nxt  = sum[POS_W-1:0];
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == CLR_W'(CLR_PAGES - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (wrap_r[in_sb] && (in_pos[PPB_W-1:0] == '0)) state_nxt = ST_SCAN;
          else                                             state_nxt = ST_FWD_RD;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          if (dst_r == CNT_W'(PAGES_PER_BLOCK)) state_nxt = ST_REFUSE;
          else                                  state_nxt = ST_TAIL;
        end
      end
      ST_TAIL: begin
        if (tail_r == PPB_W'(PAGES_PER_BLOCK - 1)) state_nxt = ST_FWD_RD;
      end
      ST_FWD_RD: state_nxt = ST_INVAL;
      ST_INVAL:  state_nxt = ST_PLACE;
      ST_PLACE:  if (out_free) state_nxt = ST_IDLE;
      ST_REFUSE: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  // Memory requests
  always_comb begin
    fwd_req = '0;
    pt_req  = '0;
    case (state_r)
      ST_CLEAR: begin
        fwd_req.we    = (clr_r < CLR_W'(LOGICAL_PAGES - 1)) ||
                        (clr_r == CLR_W'(LOGICAL_PAGES - 1));
        fwd_req.waddr = LP_W'(clr_r);
        fwd_req.wdata = '{mapped: 1'b0, page: '0};
        pt_req.we     = (clr_r < CLR_W'(PHYS_PAGES - 1)) ||
                        (clr_r == CLR_W'(PHYS_PAGES - 1));
        pt_req.waddr  = PHYS_W'(clr_r);
        pt_req.wdata  = '{invalid: 1'b1, lpage: '0};
      end
      ST_SCAN: begin
        // read page rd_cnt, move the page read last cycle down to dst
        pt_req.re    = scan_issue;
        pt_req.raddr = blk_page(sb_r, pos_r, rd_cnt_r[PPB_W-1:0]);
        if (pend_r && !pt_rdata.invalid) begin
          pt_req.we     = 1'b1;
          pt_req.waddr  = blk_page(sb_r, pos_r, dst_r[PPB_W-1:0]);
          pt_req.wdata  = '{invalid: 1'b0, lpage: pt_rdata.lpage};
          fwd_req.we    = 1'b1;
          fwd_req.waddr = pt_rdata.lpage;
          fwd_req.wdata = '{mapped: 1'b1,
                            page: blk_page(sb_r, pos_r, dst_r[PPB_W-1:0])};
        end
      end
      ST_TAIL: begin
        // free the rest of the block behind the copied pages
        pt_req.we    = 1'b1;
        pt_req.waddr = blk_page(sb_r, pos_r, tail_r);
        pt_req.wdata = '{invalid: 1'b1, lpage: '0};
      end
      ST_FWD_RD: begin
        fwd_req.re    = 1'b1;
        fwd_req.raddr = lp_r;
      end
      ST_INVAL: begin
        pt_req.we     = fwd_rdata.mapped;
        pt_req.waddr  = fwd_rdata.page;
        pt_req.wdata  = '{invalid: 1'b1, lpage: '0};
        fwd_req.we    = 1'b1;
        fwd_req.waddr = lp_r;
        fwd_req.wdata = '{mapped: 1'b1, page: phys_cur};
      end
      ST_PLACE: begin
        pt_req.we    = out_free;
        pt_req.waddr = phys_cur;
        pt_req.wdata = '{invalid: 1'b0, lpage: lp_r};
      end
      default: begin
        fwd_req = '0;
        pt_req  = '0;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      wptr_r      <= '{default: '0};
      wrap_r      <= '0;
      comp_cnt_r  <= '0;
      copy_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + CLR_W'(1);
      if ((state_r == ST_SCAN) && scan_done) begin
        comp_cnt_r <= comp_cnt_r + TOT_W'(1);
        copy_cnt_r <= copy_cnt_r + TOT_W'(dst_r);
      end
      if (out_ld) begin
        wptr_r[sb_r] <= ptr_nxt;
        if (wrap_set) wrap_r[sb_r] <= 1'b1;
      end
      if (out_ld)              out_valid_r <= 1'b1;
      else if (out_chan.ready) out_valid_r <= 1'b0;
    end
  end

  // Per-transaction working registers and result payload
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          lp_r     <= in_chan.logical_page;
          sb_r     <= in_sb;
          pos_r    <= in_pos;
          rd_cnt_r <= '0;
          pend_r   <= 1'b0;
          dst_r    <= '0;
          ran_r    <= 1'b0;
        end
      end
      ST_SCAN: begin
        pend_r <= scan_issue;
        if (scan_issue) rd_cnt_r <= rd_cnt_r + CNT_W'(1);
        if (pend_r && !pt_rdata.invalid) dst_r <= dst_r + CNT_W'(1);
        if (scan_done) begin
          ran_r  <= 1'b1;
          pos_r  <= {pos_r[POS_W-1:PPB_W], dst_r[PPB_W-1:0]};
          tail_r <= dst_r[PPB_W-1:0];
        end
      end
      ST_TAIL: tail_r <= tail_r + PPB_W'(1);
      default: ;
    endcase
    if (out_ld) begin
      out_page_r   <= refusing ? '0 : OUT_PG_W'(phys_cur);
      out_ran_r    <= ran_r;
      out_copied_r <= COPY_W'(dst_r);
      out_status_r <= refusing ? STATUS_REFUSED : STATUS_WRITTEN;
      out_ctot_r   <= comp_cnt_r;
      out_cptot_r  <= copy_cnt_r;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.physical_page    = out_page_r;
  assign out_chan.compaction_ran   = out_ran_r;
  assign out_chan.pages_copied     = out_copied_r;
  assign out_chan.status           = out_status_r;
  assign out_chan.compaction_total = out_ctot_r;
  assign out_chan.copies_total     = out_cptot_r;

  // Compaction never moves a page upwards
  a_scan_down: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && pend_r) |-> (dst_r < rd_cnt_r))
    else $error("compaction destination passed the scan position");

  // A refusal only follows a wholly valid block
  a_refuse_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REFUSE) |-> (dst_r == CNT_W'(PAGES_PER_BLOCK)))
    else $error("refusal without a wholly valid block");

  // The old mapping never lands on the page being handed out
  a_old_ne_new: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INVAL && fwd_rdata.mapped) |-> (fwd_rdata.page != phys_cur))
    else $error("old mapping equals newly assigned page");

  // The compaction counter only moves at the end of a scan
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (comp_cnt_r != $past(comp_cnt_r)) |-> ($past(state_r) == ST_SCAN))
    else $error("compaction counter moved outside a scan");

endmodule

// ===== src/flash_page_map_with_block_compaction.sv =====
// flash_page_map_with_block_compaction: top level of the page map.
// Depends on fpm_pkg, fpm_if, fpm_fwd_map, fpm_page_table and fpm_ctrl.
//
//   channel   dir  payload                                       handshake
//   in_chan   in   logical_page[8:0]                              valid/ready
//   out_chan  out  physical_page, compaction_ran, pages_copied,   valid/ready
//                  status, compaction_total, copies_total
//
// An ordinary write steps through accept, forward map read, old page
// invalidate and new page placement; each step after accept is one access
// to the memories. Entering a block of a wrapped superblock first walks it,
// then frees the tail page by page; a refused write ends after the walk.
// After reset a clearing pass over all CLR_PAGES entries holds input off.
// A result held in the output register stalls only the last step.
module flash_page_map_with_block_compaction (
  input logic       clk,
  input logic       rst_n,
  fpm_in_if.sink    in_chan,
  fpm_out_if.source out_chan
);
  import fpm_pkg::*;

  fwd_req_t   fwd_req;
  fwd_entry_t fwd_rdata;
  pt_req_t    pt_req;
  pt_entry_t  pt_rdata;

  fpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .fwd_req   (fwd_req),
    .fwd_rdata (fwd_rdata),
    .pt_req    (pt_req),
    .pt_rdata  (pt_rdata)
  );

  fpm_fwd_map u_fwd_map (
    .clk   (clk),
    .req   (fwd_req),
    .rdata (fwd_rdata)
  );

  fpm_page_table u_page_table (
    .clk   (clk),
    .req   (pt_req),
    .rdata (pt_rdata)
  );

endmodule

// ===== tb/fpm_page_map_checker.sv =====
// fpm_page_map_checker: watches both channels of the page map, keeps its own
// copy of the map state, predicts each write result and compares it.
// Depends on fpm_pkg and the fpm_in_if / fpm_out_if interfaces.
`timescale 1ns / 1ps

module fpm_page_map_checker (
  input  logic clk,
  input  logic rst_n,
  fpm_in_if    in_mon,
  fpm_out_if   out_mon,
  output int   fail_count,
  output int   pending,
  output int   results_seen,
  output int   refused_seen,
  output int   compacted_seen
);
  import fpm_pkg::*;

  typedef struct packed {
    logic [OUT_PG_W-1:0] physical_page;
    logic                compaction_ran;
    logic [COPY_W-1:0]   pages_copied;
    logic                status;
    logic [TOT_W-1:0]    compaction_total;
    logic [TOT_W-1:0]    copies_total;
  } placement_t;

  // Shadow of the map state
  logic [PHYS_W-1:0] fwd_page   [LOGICAL_PAGES];
  logic              fwd_mapped [LOGICAL_PAGES];
  logic [LP_W-1:0]   rev_lpage  [PHYS_PAGES];
  logic              pg_invalid [PHYS_PAGES];
  int unsigned       wr_pos     [SUPERBLOCKS];
  logic              wr_wrapped [SUPERBLOCKS];
  logic [TOT_W-1:0]  compaction_cnt;
  logic [TOT_W-1:0]  copy_cnt;

  placement_t pending_placements[$];

  initial begin
    fail_count     = 0;
    pending        = 0;
    results_seen   = 0;
    refused_seen   = 0;
    compacted_seen = 0;
  end

  task automatic clear_map_state();
    for (int i = 0; i < LOGICAL_PAGES; i++) begin
      fwd_page[i]   = '0;
      fwd_mapped[i] = 1'b0;
    end
    for (int i = 0; i < PHYS_PAGES; i++) begin
      rev_lpage[i]  = '0;
      pg_invalid[i] = 1'b1;
    end
    for (int i = 0; i < SUPERBLOCKS; i++) begin
      wr_pos[i]     = 0;
      wr_wrapped[i] = 1'b0;
    end
    compaction_cnt = '0;
    copy_cnt       = '0;
  endtask

  // Apply one logical page write to the shadow state and return its result
  function automatic placement_t place_write(input logic [LP_W-1:0] lp);
    placement_t  r;
    int unsigned sb, pos, base, nxt, phys, dst, live;
    logic [LP_W-1:0] moved;
    r    = '0;
    sb   = lp % SUPERBLOCKS;
    pos  = wr_pos[sb];
    if (pos >= PAGES_PER_SUPERBLOCK) pos = 0;

    // entering a block of a wrapped superblock: compact it first
    if (wr_wrapped[sb] && (pos % PAGES_PER_BLOCK) == 0) begin
      base = sb * PAGES_PER_SUPERBLOCK + pos;
      live = 0;
      for (int i = 0; i < PAGES_PER_BLOCK; i++)
        if (!pg_invalid[base + i]) live++;
      compaction_cnt   = compaction_cnt + 1;
      copy_cnt         = copy_cnt + TOT_W'(live);
      r.compaction_ran = 1'b1;
      r.pages_copied   = COPY_W'(live);
      r.compaction_total = compaction_cnt;
      r.copies_total     = copy_cnt;
      // no free page in the block: skip to the next one and refuse
      if (live == PAGES_PER_BLOCK) begin
        nxt = pos + PAGES_PER_BLOCK;
        if (nxt >= PAGES_PER_SUPERBLOCK) nxt = 0;
        wr_pos[sb] = nxt;
        r.status   = STATUS_REFUSED;
        return r;
      end
      dst = base;
      for (int unsigned i = base; i < base + PAGES_PER_BLOCK; i++) begin
        if (!pg_invalid[i]) begin
          moved          = rev_lpage[i];
          pg_invalid[i]  = 1'b1;
          rev_lpage[i]   = '0;
          fwd_page[moved]   = PHYS_W'(dst);
          fwd_mapped[moved] = 1'b1;
          rev_lpage[dst]  = moved;
          pg_invalid[dst] = 1'b0;
          dst++;
        end
      end
      pos += live;
    end

    // advance the pointer, flag the wrap
    nxt = pos + 1;
    if (nxt >= PAGES_PER_SUPERBLOCK) begin
      nxt            = 0;
      wr_wrapped[sb] = 1'b1;
    end
    wr_pos[sb] = nxt;

    // retire the old copy, map the new one
    phys = sb * PAGES_PER_SUPERBLOCK + pos;
    if (fwd_mapped[lp]) begin
      pg_invalid[fwd_page[lp]] = 1'b1;
      rev_lpage[fwd_page[lp]]  = '0;
    end
    pg_invalid[phys] = 1'b0;
    rev_lpage[phys]  = lp;
    fwd_page[lp]     = PHYS_W'(phys);
    fwd_mapped[lp]   = 1'b1;

    r.physical_page    = OUT_PG_W'(phys);
    r.status           = STATUS_WRITTEN;
    r.compaction_total = compaction_cnt;
    r.copies_total     = copy_cnt;
    return r;
  endfunction

  // Result transactions are checked before the same edge's input is predicted
  always @(posedge clk) begin
    placement_t got, want;
    if (!rst_n) begin
      clear_map_state();
      pending_placements.delete();
      pending = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.physical_page    = out_mon.physical_page;
        got.compaction_ran   = out_mon.compaction_ran;
        got.pages_copied     = out_mon.pages_copied;
        got.status           = out_mon.status;
        got.compaction_total = out_mon.compaction_total;
        got.copies_total     = out_mon.copies_total;
        results_seen++;
        if (got.status === STATUS_REFUSED) refused_seen++;
        if (got.compaction_ran === 1'b1) compacted_seen++;
        if (pending_placements.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result with nothing outstanding: page %0d ran %0b copied %0d",
                     $realtime, got.physical_page, got.compaction_ran, got.pages_copied);
        end else begin
          want = pending_placements.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: result %0d mismatch", $realtime, results_seen);
              $display("  expected page %0d ran %0b copied %0d status %0b comp %0d copies %0d",
                       want.physical_page, want.compaction_ran, want.pages_copied,
                       want.status, want.compaction_total, want.copies_total);
              $display("  actual   page %0d ran %0b copied %0d status %0b comp %0d copies %0d",
                       got.physical_page, got.compaction_ran, got.pages_copied,
                       got.status, got.compaction_total, got.copies_total);
            end
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        pending_placements.push_back(place_write(in_mon.logical_page));
      pending = pending_placements.size();
    end
  end

endmodule

// ===== tb/flash_page_map_with_block_compaction_tb.sv =====
// flash_page_map_with_block_compaction_tb: clock, reset, page write stimulus
// and result back-pressure; checking is done by fpm_page_map_checker.
// Depends on fpm_pkg, the channel interfaces, the block and the checker.
`timescale 1ns / 1ps

module flash_page_map_with_block_compaction_tb;
  import fpm_pkg::*;

  typedef enum int {SINK_OPEN, SINK_COIN, SINK_CYCLE, SINK_SPARSE} sink_mode_t;

  localparam int unsigned WIDE_SPAN = 118;   // slots per superblock for noise
  localparam int unsigned FULL_SPAN = LOGICAL_PAGES / SUPERBLOCKS;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count, pending, results_seen, refused_seen, compacted_seen;
  int   writes_sent;

  fpm_in_if  in_chan ();
  fpm_out_if out_chan ();

  flash_page_map_with_block_compaction i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  fpm_page_map_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_chan),
    .out_mon        (out_chan),
    .fail_count     (fail_count),
    .pending        (pending),
    .results_seen   (results_seen),
    .refused_seen   (refused_seen),
    .compacted_seen (compacted_seen)
  );

  always #2 clk = ~clk;

  // Hard stop
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Result side back-pressure: changing patterns plus one long hold-off
  initial begin : result_sink
    int         hold_left, mode_left, tick;
    bit         held_once;
    sink_mode_t mode;
    hold_left = 0;
    mode_left = 0;
    tick      = 0;
    held_once = 1'b0;
    mode      = SINK_OPEN;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (!held_once && results_seen >= 500) begin
        held_once = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = sink_mode_t'($urandom_range(SINK_SPARSE, SINK_OPEN));
          mode_left = $urandom_range(200, 20);
        end
        mode_left--;
        case (mode)
          SINK_OPEN:   out_chan.ready <= 1'b1;
          SINK_COIN:   out_chan.ready <= 1'($urandom_range(1, 0));
          SINK_CYCLE:  out_chan.ready <= (tick % 7) < 3;
          default:     out_chan.ready <= ($urandom_range(9, 0) != 0);
        endcase
      end
    end
  end

  task automatic send_page(input logic [LP_W-1:0] lp);
    @(negedge clk);
    in_chan.valid        <= 1'b1;
    in_chan.logical_page <= lp;
    do @(posedge clk); while (!in_chan.ready);
    writes_sent++;
  endtask

  task automatic idle_cycles(input int unsigned n);
    @(negedge clk);
    in_chan.valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Pause the writer until every outstanding result is back
  task automatic await_results();
    idle_cycles(1);
    wait (pending == 0);
    @(negedge clk);
  endtask

  // Logical page from the first span slots of a random superblock
  function automatic logic [LP_W-1:0] draw_page(input int unsigned span);
    int unsigned slot;
    slot = $urandom_range(span - 1, 0);
    return LP_W'(slot * SUPERBLOCKS + $urandom_range(SUPERBLOCKS - 1, 0));
  endfunction

  // Random writes over a working set, in bursts when gapped
  task automatic run_phase(input int unsigned span, input int unsigned count,
                           input bit gapped);
    int unsigned     burst_left;
    logic [LP_W-1:0] lp;
    burst_left = $urandom_range(24, 1);
    for (int unsigned n = 0; n < count; n++) begin
      if (gapped && burst_left == 0) begin
        idle_cycles($urandom_range(6, 1));
        burst_left = $urandom_range(24, 1);
      end
      lp = ($urandom_range(9, 0) == 0) ? draw_page(WIDE_SPAN) : draw_page(span);
      send_page(lp);
      if (burst_left > 0) burst_left--;
    end
    await_results();
  endtask

  initial begin : page_writer
    logic [LP_W-1:0] directed [20];
    writes_sent          = 0;
    rst_n                = 1'b0;
    in_chan.valid        = 1'b0;
    in_chan.logical_page = '0;
    directed = '{9'd0, 9'd511, 9'd1, 9'd2, 9'd3, 9'd256, 9'd255, 9'd0, 9'd511, 9'd4,
                 9'd8, 9'd12, 9'd128, 9'd384, 9'd170, 9'd341, 9'd510, 9'd509, 9'd508,
                 9'd1};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // extremes, rewrites of mapped pages, every superblock
    foreach (directed[i]) send_page(directed[i]);
    await_results();

    // small working set fills the superblocks before they wrap, then
    // larger sets drive compaction with more live pages and refusals
    run_phase(8, 300, 1'b1);
    run_phase(40, 400, 1'b0);
    run_phase(100, 400, 1'b1);
    run_phase(WIDE_SPAN, 430, 1'b1);
    run_phase(8, 200, 1'b1);
    run_phase(FULL_SPAN, 100, 1'b1);

    repeat (60) @(posedge clk);
    $display("Wrote %0d logical pages, %0d results checked", writes_sent, results_seen);
    $display("Compactions seen: %0d, refused writes: %0d", compacted_seen, refused_seen);
    if (fail_count == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
src/fpm_pkg.sv
src/fpm_if.sv
src/fpm_fwd_map.sv
src/fpm_page_table.sv
src/fpm_ctrl.sv
src/flash_page_map_with_block_compaction.sv
tb/fpm_page_map_checker.sv
tb/flash_page_map_with_block_compaction_tb.sv
